>>> rtl/mfbw_pkg.sv
// ----------------------------------------------------------------------------
// mfbw_pkg
// Shared types and constants of the MSB-first bit stream writer.
// ----------------------------------------------------------------------------
package mfbw_pkg;

    // Field widths of the input and result words.
    localparam int NUM_BITS_W   = 6;
    localparam int VALUE_W      = 32;
    localparam int LOC_W        = 15;
    localparam int BYTE_W       = 8;
    localparam int ADDR_FIELD_W = 12;
    localparam int WPOS_W       = 15;

    // Packed bus widths, padded up to whole bytes.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    // Bit positions inside a byte count down from the MSB.
    localparam logic [2:0] BIT_TOP = 3'd7;

    // Fixed-point shift of the reciprocal used to reduce poke addresses.
    localparam int RECIP_SHIFT = 24;

    // Control sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOAD   = 4'b0100,
        ST_MODIFY = 4'b1000
    } state_t;

    // Result of merging new bits into one stored byte.
    typedef struct packed {
        logic [BYTE_W-1:0]     new_byte;
        logic [3:0]            used;
        logic [NUM_BITS_W-1:0] rem_next;
        logic                  last;
        logic                  wrap;
        logic [2:0]            pos_next;
    } merge_t;

endpackage

>>> rtl/msb_first_bit_writer.sv
// An accepted word moves through an address setup state, which starts a registered
// store read, and a byte update state, which registers each byte word at the output.
// The store does one read-modify-write per cycle on its port, as long as the output
// register is free; a full output register stalls it. A new word is taken only once
// the last byte of the current one is registered. An item of zero bits writes nothing.
// Reset: a clearing pass zeroes every byte of the store; tready is low.
// ----------------------------------------------------------------------------
// msb_first_bit_writer
// Bit stream writer: appends or pokes code words MSB first into a byte store
// and gives out each byte it rewrites.
// ----------------------------------------------------------------------------
module msb_first_bit_writer #(
    parameter int STORE_BYTES = 4096,
    parameter int MAX_BITS    = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input word.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: num_bits[5:0], value[37:6], bit_location[52:38], zero pad.
    input  logic [mfbw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: func (0 append, 1 poke).
    input  logic                               s_axis_tuser,
    // Result word.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: byte_address[11:0], byte_value[19:12], write_position[34:20].
    output logic [mfbw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tlast: last_byte.
    output logic                               m_axis_tlast
);
    import mfbw_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
    localparam logic [AW:0]   DEPTH     = (AW + 1)'(STORE_BYTES);
    localparam int RECIP = (1 << RECIP_SHIFT) / STORE_BYTES;
    localparam logic [NUM_BITS_W-1:0] BITS_CAP = NUM_BITS_W'(MAX_BITS);

    // Byte store.
    logic [BYTE_W-1:0] mem [STORE_BYTES];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] rdata_reg;

    // Control and item state.
    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]         bp_reg, bp_next;
    logic [2:0]            bit_reg, bit_next;
    logic                  func_reg, func_next;
    logic [NUM_BITS_W-1:0] rem_reg, rem_next;
    logic [VALUE_W-1:0]    val_reg, val_next;
    logic [11:0]           loc_reg, loc_next;
    logic [11:0]           q_reg, q_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [2:0]            pos_reg, pos_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic [ADDR_FIELD_W-1:0] out_addr_reg;
    logic [BYTE_W-1:0]       out_byte_reg;
    logic                    out_last_reg;
    logic [WPOS_W-1:0]       out_wp_reg;
    logic                    load_out;

    // Helpers.
    logic [NUM_BITS_W-1:0] n_in;
    logic [NUM_BITS_W-1:0] n_clamp;
    logic [VALUE_W-1:0]    value_in;
    logic [LOC_W-1:0]      loc_in;
    logic [AW+3:0]         lin_end;
    logic [AW:0]           bp_adv;
    logic [32:0]           recip_prod;
    logic [32:0]           loc_rem;
    logic [AW-1:0]         poke_addr;
    logic [AW-1:0]         addr_inc;
    logic                  out_free;
    merge_t                mrg;

    assign n_in     = s_axis_tdata[5:0];
    assign value_in = s_axis_tdata[37:6];
    assign loc_in   = s_axis_tdata[52:38];
    assign n_clamp  = (n_in > BITS_CAP) ? BITS_CAP : n_in;

    // Running position advanced by the item, wrapping the byte pointer once.
    always_comb
    begin
        lin_end = {1'b0, bp_reg, ~bit_reg} + (AW + 4)'(n_clamp);
        bp_adv  = lin_end[AW+3:3];
        if (bp_adv >= DEPTH)
        begin
            bp_adv = bp_adv - DEPTH;
        end
    end

    // Poke byte address modulo the depth: reciprocal estimate, then one fix-up.
    assign recip_prod = 33'(loc_in[LOC_W-1:3]) * 33'(RECIP);
    always_comb
    begin
        loc_rem = 33'(loc_reg) - 33'(q_reg) * 33'(STORE_BYTES);
        if (loc_rem >= 33'(STORE_BYTES))
        begin
            loc_rem = loc_rem - 33'(STORE_BYTES);
        end
        poke_addr = AW'(loc_rem);
    end

    assign addr_inc = (addr_reg == LAST_ADDR) ? '0 : addr_reg + AW'(1);
    assign out_free = !out_valid_reg || m_axis_tready;

    mfbw_merge u_merge (
        .old_byte (rdata_reg),
        .pos      (pos_reg),
        .rem      (rem_reg),
        .bits     (val_reg[VALUE_W-1:VALUE_W-8]),
        .res      (mrg)
    );

    // Sequencer: clearing pass, item intake, address setup, byte updates.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        bp_next      = bp_reg;
        bit_next     = bit_reg;
        func_next    = func_reg;
        rem_next     = rem_reg;
        val_next     = val_reg;
        loc_next     = loc_reg;
        q_next       = q_reg;
        addr_next    = addr_reg;
        pos_next     = pos_reg;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = mrg.new_byte;
        mem_re       = 1'b0;
        mem_raddr    = addr_reg;
        load_out     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid && (n_clamp != '0))
                begin
                    func_next = s_axis_tuser;
                    rem_next  = n_clamp;
                    val_next  = value_in << (NUM_BITS_W'(VALUE_W) - n_clamp);
                    loc_next  = loc_in[LOC_W-1:3];
                    q_next    = 12'(recip_prod >> RECIP_SHIFT);
                    if (s_axis_tuser)
                    begin
                        pos_next = ~loc_in[2:0];
                    end
                    else
                    begin
                        addr_next = bp_reg;
                        pos_next  = bit_reg;
                        bp_next   = AW'(bp_adv);
                        bit_next  = ~lin_end[2:0];
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = func_reg ? poke_addr : addr_reg;
                addr_next  = mem_raddr;
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                if (out_free)
                begin
                    mem_we   = 1'b1;
                    load_out = 1'b1;
                    rem_next = mrg.rem_next;
                    val_next = val_reg << mrg.used;
                    pos_next = mrg.wrap ? BIT_TOP : mrg.pos_next;
                    if (mrg.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // More bits remain, so this byte is full: fetch the next one.
                        mem_re    = 1'b1;
                        mem_raddr = addr_inc;
                        addr_next = addr_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            bp_reg        <= '0;
            bit_reg       <= BIT_TOP;
            func_reg      <= 1'b0;
            rem_reg       <= '0;
            addr_reg      <= '0;
            pos_reg       <= BIT_TOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            bp_reg        <= bp_next;
            bit_reg       <= bit_next;
            func_reg      <= func_next;
            rem_reg       <= rem_next;
            addr_reg      <= addr_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        loc_reg <= loc_next;
        q_reg   <= q_next;
        if (load_out)
        begin
            out_addr_reg <= ADDR_FIELD_W'(addr_reg);
            out_byte_reg <= mrg.new_byte;
            out_last_reg <= mrg.last;
            out_wp_reg   <= WPOS_W'({bp_reg, ~bit_reg});
        end
    end

    // Store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Ports.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'b0, out_wp_reg, out_byte_reg, out_addr_reg};

    // The address setup cycle is always followed by a byte update.
    a_load_then_modify: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_MODIFY))
        else $error("address setup not followed by byte update");

    // A byte update always has bits left to write.
    a_modify_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODIFY) |-> (rem_reg != '0))
        else $error("byte update with no bits left");

    // Working address and byte pointer stay inside the store.
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, addr_reg} < DEPTH) && ({1'b0, bp_reg} < DEPTH))
        else $error("store address out of range");

    // No result word is shown during the clearing pass.
    a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("result word during clearing pass");

endmodule

>>> rtl/mfbw_merge.sv
// ----------------------------------------------------------------------------
// mfbw_merge
// Merges the next run of stream bits into one stored byte, MSB first.
// ----------------------------------------------------------------------------
module mfbw_merge (
    input  logic [7:0]          old_byte,  // current store contents
    input  logic [2:0]          pos,       // first bit position to write
    input  logic [5:0]          rem,       // bits still to write in this item
    input  logic [7:0]          bits,      // next stream bits, left aligned
    output mfbw_pkg::merge_t    res
);
    import mfbw_pkg::*;

    logic [3:0] room;
    logic [3:0] used;
    logic [2:0] delta;

    // Count the bits that land in this byte and where the position goes next,
    // then replace the written bits and keep every other bit of the byte.
    always_comb
    begin
        room = 4'(pos) + 4'd1;
        used = (rem < 6'(room)) ? 4'(rem) : room;

        res.used     = used;
        res.rem_next = rem - 6'(used);
        res.last     = (rem == 6'(used));
        res.wrap     = (used == room);
        res.pos_next = pos - 3'(used);

        delta = '0;
        res.new_byte = old_byte;
        for (int i = 0; i < BYTE_W; i++)
        begin
            delta = pos - 3'(i);
            if ((3'(i) <= pos) && (4'(delta) < used))
            begin
                res.new_byte[i] = bits[BIT_TOP - delta];
            end
        end
    end

endmodule
